// ===== rtl/tcs_pkg.sv =====
// Shared constants, types and character class functions for the clause segmenter.
`timescale 1ns / 1ps
package tcs_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int AW   = $clog2(BUFFER_DEPTH);
  localparam int CW   = $clog2(BUFFER_DEPTH + 1);
  localparam int CPW  = 21;
  localparam int CFGW = 7;

  typedef logic [CPW-1:0] cp_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_dec;
    logic scan_found;
    logic emit_start;
    logic emit_skip;
    logic emit_load;
    logic emit_done;
    logic rd_en;
    logic sel_b;
  } dp_cmd_t;

  typedef struct packed {
    logic is_ws;
    logic at_lo;
    logic at_last;
    logic a_ne;
    logic b_ne;
    logic va;
    logic vb;
    logic sel_b;
    logic started;
    logic out_free;
  } dp_stat_t;

  function automatic logic is_delim(cp_t c);
    return c == CPW'(32'h2E) || c == CPW'(32'h3B) || c == CPW'(32'h21) ||
           c == CPW'(32'h3F) || c == CPW'(32'h3002) || c == CPW'(32'hFF1B) ||
           c == CPW'(32'hFF01) || c == CPW'(32'hFF1F) || c == CPW'(32'h0A) ||
           c == CPW'(32'h0D);
  endfunction

  function automatic logic is_alnum(cp_t c);
    return (c >= CPW'(32'h30) && c <= CPW'(32'h39)) ||
           (c >= CPW'(32'h41) && c <= CPW'(32'h5A)) ||
           (c >= CPW'(32'h61) && c <= CPW'(32'h7A));
  endfunction

  function automatic logic is_ws(cp_t c);
    return c == CPW'(32'h20) || (c >= CPW'(32'h09) && c <= CPW'(32'h0D));
  endfunction

  function automatic logic is_sptab(cp_t c);
    return c == CPW'(32'h20) || c == CPW'(32'h09);
  endfunction

  // Maps a position relative to a ring base onto a buffer address.
  function automatic logic [AW-1:0] phys_addr(logic [AW-1:0] base, logic [CW-1:0] rel);
    logic [CW:0] sum;
    sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, rel};
    if (sum >= (CW + 1)'(BUFFER_DEPTH)) sum = sum - (CW + 1)'(BUFFER_DEPTH);
    return sum[AW-1:0];
  endfunction

endpackage

// ===== rtl/tcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tcs_datapath.sv =====
// Clause buffer ring, cut-point tracking, span scanning and output register.
`timescale 1ns / 1ps
module tcs_datapath import tcs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [CFGW-1:0] cfg_wdata,
  input  cp_t             in_code_point,
  input  logic            in_end_of_text,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat,
  output logic            out_valid,
  input  logic            out_ready,
  output cp_t             out_char,
  output logic            out_segment_end,
  output logic            out_run_last
);

  logic [CFGW-1:0] cfg_r;
  logic [CW-1:0]   count_r, safe_r;
  logic            inword_r;
  logic [AW-1:0]   base_r, eb_r;
  logic [CW-1:0]   a_hi_r, b_lo_r, b_hi_r, la_r, lb_r, idx_r;
  logic            va_r, vb_r, sel_r, started_r;
  logic            out_valid_r, seg_end_r, run_last_r;
  cp_t             out_char_r;

  logic [CW-1:0]   lim, safe1, count1, n_count, n_safe, a_hi_nxt, b_lo_nxt, b_hi_nxt;
  logic            inw1, n_inw, c_delim, c_an, wr_en;
  logic [AW-1:0]   n_base;
  logic [CW-1:0]   lo_sel, last_sel;
  cp_t             rdata;

  always_comb begin
    if (cfg_r == '0 || cfg_r > CFGW'(BUFFER_DEPTH)) lim = CW'(BUFFER_DEPTH);
    else lim = cfg_r[CW-1:0];
    c_delim = is_delim(in_code_point);
    c_an    = is_alnum(in_code_point);
    safe1   = safe_r;
    inw1    = inword_r;
    if (is_sptab(in_code_point)) begin
      safe1 = count_r;
      inw1  = 1'b0;
    end else if (!inword_r && c_an) begin
      safe1 = count_r;
      inw1  = 1'b1;
    end else if (inword_r && !c_an) begin
      safe1 = count_r;
      inw1  = 1'b0;
    end
    count1 = (count_r < CW'(BUFFER_DEPTH)) ? count_r + CW'(1) : count_r;
    wr_en  = cmd.accept && !c_delim && (count_r < CW'(BUFFER_DEPTH));
    n_base = base_r;
    if (c_delim) begin
      a_hi_nxt = count_r;
      b_lo_nxt = '0;
      n_count  = '0;
      n_safe   = '0;
      n_inw    = 1'b0;
    end else if (count1 >= lim) begin
      if (safe1 != '0 && safe1 < count1) begin
        a_hi_nxt = safe1;
        b_lo_nxt = safe1;
        n_count  = count1 - safe1;
        n_base   = phys_addr(base_r, safe1);
      end else begin
        a_hi_nxt = count1;
        b_lo_nxt = count1;
        n_count  = '0;
      end
      n_safe = '0;
      n_inw  = 1'b0;
    end else begin
      a_hi_nxt = '0;
      b_lo_nxt = '0;
      n_count  = count1;
      n_safe   = safe1;
      n_inw    = inw1;
    end
    b_hi_nxt = b_lo_nxt;
    if (in_end_of_text) begin
      b_hi_nxt = b_lo_nxt + n_count;
      n_count  = '0;
      n_safe   = '0;
      n_inw    = 1'b0;
    end
  end

  tcs_ram #(.W(CPW), .D(BUFFER_DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (phys_addr(base_r, count_r)),
    .wdata (in_code_point),
    .re    (cmd.rd_en),
    .raddr (phys_addr(eb_r, idx_r)),
    .rdata (rdata)
  );

  assign lo_sel   = sel_r ? b_lo_r : '0;
  assign last_sel = sel_r ? lb_r : la_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      count_r     <= '0;
      safe_r      <= '0;
      inword_r    <= 1'b0;
      base_r      <= '0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cfg_r <= cfg_wdata;
      if (cmd.accept) begin
        count_r  <= n_count;
        safe_r   <= n_safe;
        inword_r <= n_inw;
        base_r   <= n_base;
        va_r     <= 1'b0;
        vb_r     <= 1'b0;
      end
      if (cmd.scan_found) begin
        if (sel_r) vb_r <= 1'b1;
        else va_r <= 1'b1;
      end
      if (cmd.emit_done) begin
        if (sel_r) vb_r <= 1'b0;
        else va_r <= 1'b0;
      end
      if (cmd.emit_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      eb_r   <= base_r;
      a_hi_r <= a_hi_nxt;
      b_lo_r <= b_lo_nxt;
      b_hi_r <= b_hi_nxt;
    end
    if (cmd.scan_start) begin
      sel_r <= cmd.sel_b;
      idx_r <= (cmd.sel_b ? b_hi_r : a_hi_r) - CW'(1);
    end else if (cmd.scan_dec) begin
      idx_r <= idx_r - CW'(1);
    end else if (cmd.emit_start) begin
      sel_r     <= cmd.sel_b;
      idx_r     <= cmd.sel_b ? b_lo_r : '0;
      started_r <= 1'b0;
    end else if (cmd.emit_skip || cmd.emit_load) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.scan_found) begin
      if (sel_r) lb_r <= idx_r;
      else la_r <= idx_r;
    end
    if (cmd.emit_load) begin
      started_r  <= 1'b1;
      out_char_r <= rdata;
      seg_end_r  <= idx_r == last_sel;
      run_last_r <= (idx_r == last_sel) && (sel_r || !vb_r);
    end
  end

  assign stat.is_ws    = is_ws(rdata);
  assign stat.at_lo    = idx_r == lo_sel;
  assign stat.at_last  = idx_r == last_sel;
  assign stat.a_ne     = a_hi_r != '0;
  assign stat.b_ne     = b_hi_r != b_lo_r;
  assign stat.va       = va_r;
  assign stat.vb       = vb_r;
  assign stat.sel_b    = sel_r;
  assign stat.started  = started_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_segment_end = seg_end_r;
  assign out_run_last    = run_last_r;

endmodule

// ===== rtl/tcs_ctrl.sv =====
// Controller state machine that sequences accept, trim scans and word emission.
`timescale 1ns / 1ps
module tcs_ctrl import tcs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PLAN    = 3'd1;
  localparam logic [2:0] S_SC_RD   = 3'd2;
  localparam logic [2:0] S_SC_CHK  = 3'd3;
  localparam logic [2:0] S_EM_PLAN = 3'd4;
  localparam logic [2:0] S_EM_RD   = 3'd5;
  localparam logic [2:0] S_EM_CHK  = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PLAN;
        end
      end
      S_PLAN: begin
        if (stat.b_ne) begin
          cmd.scan_start = 1'b1;
          cmd.sel_b      = 1'b1;
          state_nxt      = S_SC_RD;
        end else if (stat.a_ne) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SC_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SC_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (stat.is_ws && !stat.at_lo) begin
          cmd.scan_dec = 1'b1;
          state_nxt    = S_SC_RD;
        end else begin
          cmd.scan_found = !stat.is_ws;
          if (stat.sel_b && stat.a_ne) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SC_RD;
          end else begin
            state_nxt = S_EM_PLAN;
          end
        end
      end
      S_EM_PLAN: begin
        if (stat.va) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EM_RD;
        end else if (stat.vb) begin
          cmd.emit_start = 1'b1;
          cmd.sel_b      = 1'b1;
          state_nxt      = S_EM_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EM_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EM_CHK;
      end
      S_EM_CHK: begin
        if (!stat.started && stat.is_ws) begin
          cmd.emit_skip = 1'b1;
          state_nxt     = S_EM_RD;
        end else if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.at_last) begin
            cmd.emit_done = 1'b1;
            state_nxt     = S_EM_PLAN;
          end else begin
            state_nxt = S_EM_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ===== rtl/text_clause_segmenter.sv =====
// Top level of the clause segmenter: controller, datapath and port wiring.
// Sequence: accept, a planning step, then per flushed segment a start step and a read and
// a check step for each character scanned back, skipped or emitted.
// New words are taken only in the idle state; output stalls hold the emitter.
// Synchronous active-low reset empties the clause and sets the limit register
// to zero; the buffer RAM itself is not cleared.
`timescale 1ns / 1ps
module text_clause_segmenter import tcs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [CFGW-1:0] cfg_wdata,
  input  logic            in_valid,
  output logic            in_ready,
  input  cp_t             in_code_point,
  input  logic            in_end_of_text,
  output logic            out_valid,
  input  logic            out_ready,
  output cp_t             out_char,
  output logic            out_segment_end,
  output logic            out_run_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcs_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_code_point   (in_code_point),
    .in_end_of_text  (in_end_of_text),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_segment_end (out_segment_end),
    .out_run_last    (out_run_last)
  );

endmodule

// ===== verif/tb_text_clause_segmenter.sv =====
// Self-checking testbench for the clause segmenter: random and directed text against a predictor.
`timescale 1ns / 1ps
module tb_text_clause_segmenter;
  import tcs_pkg::*;

  localparam int DEPTH = BUFFER_DEPTH;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 20;

  localparam cp_t CH_NUL        = 21'h000000;
  localparam cp_t CH_TAB        = 21'h000009;
  localparam cp_t CH_LF         = 21'h00000A;
  localparam cp_t CH_VT         = 21'h00000B;
  localparam cp_t CH_FF         = 21'h00000C;
  localparam cp_t CH_CR         = 21'h00000D;
  localparam cp_t CH_SPACE      = 21'h000020;
  localparam cp_t CH_BANG       = 21'h000021;
  localparam cp_t CH_PERIOD     = 21'h00002E;
  localparam cp_t CH_SEMI       = 21'h00003B;
  localparam cp_t CH_QUEST      = 21'h00003F;
  localparam cp_t CH_IDEO_STOP  = 21'h003002;
  localparam cp_t CH_FW_BANG    = 21'h00FF01;
  localparam cp_t CH_FW_SEMI    = 21'h00FF1B;
  localparam cp_t CH_FW_QUEST   = 21'h00FF1F;
  localparam cp_t CH_CJK        = 21'h004E2D;
  localparam cp_t CH_UNI_MAX    = 21'h10FFFF;
  localparam cp_t CH_ALL_ONES   = 21'h1FFFFF;

  typedef struct packed {
    cp_t  cp;
    logic eot;
    logic drain_first;
  } word_t;

  typedef struct packed {
    cp_t  ch;
    logic seg_end;
    logic last;
  } seg_char_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [CFGW-1:0] cfg_wdata = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  cp_t             in_code_point = '0;
  logic            in_end_of_text = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  cp_t             out_char;
  logic            out_segment_end;
  logic            out_run_last;

  text_clause_segmenter uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_code_point(in_code_point),
    .in_end_of_text(in_end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char(out_char),
    .out_segment_end(out_segment_end),
    .out_run_last(out_run_last)
  );

  always #2 clk = ~clk;

  word_t       words_to_send[$];
  seg_char_t   expected_chars[$];
  word_t       next_word;
  seg_char_t   got_char;

  cp_t             clause_buf[0:DEPTH-1];
  int              clause_len;
  int              cut_pos;
  bit              alnum_run;
  logic [CFGW-1:0] limit_reg;
  int              step_results;

  int err_count = 0;
  int words_accepted = 0;
  int chars_checked = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic bit ends_sentence(cp_t c);
    case (c)
      CH_PERIOD, CH_SEMI, CH_BANG, CH_QUEST, CH_IDEO_STOP, CH_FW_SEMI,
      CH_FW_BANG, CH_FW_QUEST, CH_LF, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_blank(cp_t c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_word_char(cp_t c);
    return (c >= 21'h30 && c <= 21'h39) || (c >= 21'h41 && c <= 21'h5A) ||
           (c >= 21'h61 && c <= 21'h7A);
  endfunction

  // Queues the trimmed characters of clause_buf[0..hi) as one segment.
  function automatic void emit_trimmed(int hi);
    int lo;
    int i;
    seg_char_t r;
    lo = 0;
    while (lo < hi && is_blank(clause_buf[lo])) lo++;
    while (hi > lo && is_blank(clause_buf[hi-1])) hi--;
    for (i = lo; i < hi && step_results < DEPTH; i++) begin
      r.ch = clause_buf[i];
      r.seg_end = (i + 1 == hi);
      r.last = 1'b0;
      expected_chars.push_back(r);
      step_results++;
    end
  endfunction

  function automatic void predict_word(cp_t c, logic eot);
    int lim;
    int keep;
    int i;
    bit alnum;
    seg_char_t r;
    lim = limit_reg;
    if (lim == 0 || lim > DEPTH) lim = DEPTH;
    step_results = 0;
    if (ends_sentence(c)) begin
      emit_trimmed(clause_len);
      clause_len = 0;
      cut_pos = 0;
      alnum_run = 1'b0;
    end else begin
      alnum = is_word_char(c);
      if (c == CH_SPACE || c == CH_TAB) begin
        cut_pos = clause_len;
        alnum_run = 1'b0;
      end else if (!alnum_run && alnum) begin
        cut_pos = clause_len;
        alnum_run = 1'b1;
      end else if (alnum_run && !alnum) begin
        cut_pos = clause_len;
        alnum_run = 1'b0;
      end
      if (clause_len < DEPTH) begin
        clause_buf[clause_len] = c;
        clause_len++;
      end
      if (clause_len >= lim) begin
        if (cut_pos > 0 && cut_pos < clause_len) begin
          keep = clause_len - cut_pos;
          emit_trimmed(cut_pos);
          for (i = 0; i < keep; i++) clause_buf[i] = clause_buf[i + cut_pos];
          clause_len = keep;
        end else begin
          emit_trimmed(clause_len);
          clause_len = 0;
        end
        cut_pos = 0;
        alnum_run = 1'b0;
      end
    end
    if (eot) begin
      emit_trimmed(clause_len);
      clause_len = 0;
      cut_pos = 0;
      alnum_run = 1'b0;
    end
    if (step_results > 0) begin
      r = expected_chars.pop_back();
      r.last = 1'b1;
      expected_chars.push_back(r);
    end
  endfunction

  function automatic cp_t pick_delimiter(int k);
    case (k)
      0: return CH_PERIOD;
      1: return CH_SEMI;
      2: return CH_BANG;
      3: return CH_QUEST;
      4: return CH_IDEO_STOP;
      5: return CH_FW_SEMI;
      6: return CH_FW_BANG;
      7: return CH_FW_QUEST;
      8: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic cp_t random_alnum();
    int k;
    k = $urandom_range(61);
    if (k < 10) return cp_t'(21'h30 + k);
    if (k < 36) return cp_t'(21'h41 + k - 10);
    return cp_t'(21'h61 + k - 36);
  endfunction

  // Mostly plausible text with occasional noise and class-boundary characters.
  function automatic cp_t random_code_point();
    int r;
    r = $urandom_range(99);
    if (r < 40) return random_alnum();
    if (r < 53) return CH_SPACE;
    if (r < 58) return cp_t'(CH_TAB + $urandom_range(4));
    if (r < 73) return cp_t'(21'h4E00 + $urandom_range(21'h51FF));
    if (r < 83) return pick_delimiter($urandom_range(9));
    if (r < 89) return cp_t'(21'h21 + $urandom_range(21'h5D));
    if (r < 95) return cp_t'($urandom_range(CH_ALL_ONES));
    case ($urandom_range(7))
      0: return cp_t'(21'h2F);
      1: return cp_t'(21'h3A);
      2: return cp_t'(21'h40);
      3: return cp_t'(21'h5B);
      4: return cp_t'(21'h60);
      5: return cp_t'(21'h7B);
      6: return cp_t'(21'h08);
      default: return cp_t'(21'h0E);
    endcase
  endfunction

  task automatic queue_word(cp_t c, logic eot, logic drain);
    word_t w;
    w.cp = c;
    w.eot = eot;
    w.drain_first = drain;
    words_to_send.push_back(w);
  endtask

  task automatic wait_until_idle();
    while (words_to_send.size() != 0 || in_valid || expected_chars.size() != 0 ||
           !in_ready)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFGW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    limit_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_word(in_code_point, in_end_of_text);
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (words_to_send.size() != 0 &&
            !(words_to_send[0].drain_first && expected_chars.size() != 0) &&
            $urandom_range(99) >= src_idle_pct) begin
          next_word = words_to_send.pop_front();
          in_valid <= 1'b1;
          in_code_point <= next_word.cp;
          in_end_of_text <= next_word.eot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char %h", out_char));
        end else begin
          got_char = expected_chars.pop_front();
          if (out_char !== got_char.ch)
            report_mismatch($sformatf("out_char %h, want %h", out_char, got_char.ch));
          if (out_segment_end !== got_char.seg_end)
            report_mismatch($sformatf("segment_end %b, want %b on char %h",
                                      out_segment_end, got_char.seg_end, got_char.ch));
          if (out_run_last !== got_char.last)
            report_mismatch($sformatf("run_last %b, want %b on char %h",
                                      out_run_last, got_char.last, got_char.ch));
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    int p;
    int i;
    logic [CFGW-1:0] phase_limit;
    clause_len = 0;
    cut_pos = 0;
    alnum_run = 1'b0;
    limit_reg = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The opening clause mixes leading and trailing blanks, CJK and an out-of-range code.
    queue_word(CH_SPACE, 1'b0, 1'b0);
    queue_word(cp_t'(21'h41), 1'b0, 1'b0);
    queue_word(CH_CJK, 1'b0, 1'b0);
    queue_word(CH_ALL_ONES, 1'b0, 1'b0);
    queue_word(CH_VT, 1'b0, 1'b0);
    queue_word(CH_PERIOD, 1'b0, 1'b0);
    queue_word(CH_FF, 1'b0, 1'b0);
    queue_word(CH_TAB, 1'b0, 1'b0);
    queue_word(CH_SEMI, 1'b0, 1'b0);
    queue_word(CH_NUL, 1'b0, 1'b0);
    queue_word(CH_BANG, 1'b0, 1'b0);
    queue_word(cp_t'(21'h7A), 1'b0, 1'b0);
    queue_word(CH_QUEST, 1'b0, 1'b0);
    queue_word(CH_UNI_MAX, 1'b0, 1'b0);
    queue_word(CH_IDEO_STOP, 1'b0, 1'b0);
    queue_word(cp_t'(21'h39), 1'b0, 1'b0);
    queue_word(CH_FW_SEMI, 1'b0, 1'b0);
    queue_word(cp_t'(21'h51), 1'b0, 1'b0);
    queue_word(CH_FW_BANG, 1'b0, 1'b0);
    queue_word(cp_t'(21'h61), 1'b0, 1'b0);
    queue_word(CH_FW_QUEST, 1'b0, 1'b0);
    queue_word(cp_t'(21'h30), 1'b0, 1'b0);
    queue_word(CH_LF, 1'b0, 1'b0);
    queue_word(cp_t'(21'h5A), 1'b0, 1'b0);
    queue_word(CH_CR, 1'b1, 1'b0);
    queue_word(cp_t'(21'h35), 1'b1, 1'b0);
    wait_until_idle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_limit = 7'd64;
        1: phase_limit = 7'd1;
        2: phase_limit = 7'd127;
        3: phase_limit = 7'd8;
        4: phase_limit = 7'd3;
        5: phase_limit = 7'd65;
        6: phase_limit = 7'd12;
        7: phase_limit = 7'd2;
        8: phase_limit = 7'd0;
        default: phase_limit = 7'd20;
      endcase
      case (p % 4)
        0: begin src_idle_pct = 0; sink_stall_pct = 0; end
        1: begin src_idle_pct = 48; sink_stall_pct = 0; end
        2: begin src_idle_pct = 0; sink_stall_pct = 48; end
        default: begin src_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      write_limit(phase_limit);
      for (i = 0; i < WORDS_PER_PHASE - 1; i++)
        queue_word(random_code_point(), $urandom_range(99) < 4,
                   (p == 0 && i == 5) || $urandom_range(19) == 0);
      // Leave part of a clause buffered so the next limit applies mid-clause.
      queue_word(random_alnum(), 1'b0, 1'b0);
      wait_until_idle();
    end

    repeat (20) @(posedge clk);
    if (expected_chars.size() != 0)
      report_mismatch($sformatf("%0d chars never arrived", expected_chars.size()));
    $display("Sent %0d words through %0d limit settings and four idle patterns.",
             words_accepted, PHASES + 1);
    $display("Checked %0d output chars, %0d mismatches.", chars_checked, err_count);
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d chars still expected.", expected_chars.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ===== text_clause_segmenter.f =====
rtl/tcs_pkg.sv
rtl/tcs_ram.sv
rtl/tcs_datapath.sv
rtl/tcs_ctrl.sv
rtl/text_clause_segmenter.sv
verif/tb_text_clause_segmenter.sv
